[rtl/chte_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// chte_pkg
// Shared types and constants of the chained hash table engine.
// ----------------------------------------------------------------------------
package chte_pkg;

    localparam int unsigned BUCKETS_DEF = 256;
    localparam int unsigned NODES_DEF   = 1024;

    typedef enum logic [1:0] {
        OP_PUT    = 2'd0,
        OP_LOOKUP = 2'd1,
        OP_REMOVE = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_BAD_KEY   = 2'd2,
        ST_FULL      = 2'd3
    } t_status;

    typedef enum logic {
        CFG_BUCKETS = 1'b0,
        CFG_MULT    = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic [1:0]  operation;
        logic [63:0] lookup_key;
        logic [63:0] value_word;
        logic        capture_flag;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  status;
        logic [63:0] found_value;
        logic        found_flag;
        logic [10:0] entry_count;
    } t_out_item;

    // classified item handed from front to back
    typedef struct packed {
        logic [1:0]  operation;
        logic        bad_key;
        logic [63:0] lookup_key;
        logic [63:0] value_word;
        logic        capture_flag;
        logic [63:0] hash;
    } t_job;

    typedef enum logic [3:0] {
        B_IDLE,
        B_MOD,
        B_HEAD,
        B_RD,
        B_CMP,
        B_WR,
        B_FREE,
        B_DONE
    } t_bstate;

endpackage
`default_nettype wire

[rtl/chte_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// chte_front
// Accepts items, checks the key and forms the 64-bit product hash over
// three 32x32 partial products, then pushes a job into a two-entry queue.
// ----------------------------------------------------------------------------
module chte_front (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_start,
    input  chte_pkg::t_in_item  i_item,
    input  wire [63:0]          i_mult,
    output logic                o_busy,
    output logic                o_job_valid,
    output chte_pkg::t_job      o_job,
    input  wire                 i_job_pop
);
    import chte_pkg::*;

    logic        r_act, n_act;
    logic [1:0]  r_ph, n_ph;
    t_in_item    r_item;
    logic [63:0] r_acc, n_acc;
    logic [63:0] r_mul;
    t_job        r_q [2];
    logic [1:0]  r_cnt, n_cnt;
    logic        r_rp, r_wp;
    logic [31:0] w_a, w_b;
    logic [63:0] w_p;
    logic        w_push;

    assign o_busy      = r_act || (r_cnt == 2'd2);
    assign o_job_valid = (r_cnt != 2'd0);
    assign o_job       = r_q[r_rp];

    always_comb begin
        w_a = r_ph[1] ? r_item.lookup_key[63:32] : r_item.lookup_key[31:0];
        w_b = r_ph[0] ? r_mul[63:32] : r_mul[31:0];
        w_p = 64'(w_a) * 64'(w_b);
    end

    always_comb begin
        n_act  = r_act;
        n_ph   = r_ph;
        n_acc  = r_acc;
        w_push = 1'b0;
        if (!r_act) begin
            if (i_start && !o_busy) begin
                n_act = 1'b1;
                n_ph  = 2'd0;
                n_acc = '0;
            end
        end else begin
            case (r_ph) inside
                2'd0: n_acc = w_p;
                2'd1, 2'd2: n_acc = r_acc + {w_p[31:0], 32'd0};
                default: n_acc = r_acc;
            endcase
            n_ph = r_ph + 2'd1;
            if (r_ph == 2'd2) begin
                n_act  = 1'b0;
                w_push = 1'b1;
            end
        end
        n_cnt = r_cnt + {1'b0, w_push} - {1'b0, i_job_pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act <= 1'b0;
            r_ph  <= '0;
            r_cnt <= '0;
            r_rp  <= 1'b0;
            r_wp  <= 1'b0;
        end else begin
            r_act <= n_act;
            r_ph  <= n_ph;
            r_cnt <= n_cnt;
            if (w_push) r_wp <= ~r_wp;
            if (i_job_pop) r_rp <= ~r_rp;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
        if (!r_act && i_start && !o_busy) begin
            r_item <= i_item;
            r_mul  <= i_mult;
        end
        if (w_push) begin
            r_q[r_wp].operation    <= r_item.operation;
            r_q[r_wp].bad_key      <= (r_item.lookup_key == 64'd0);
            r_q[r_wp].lookup_key   <= r_item.lookup_key;
            r_q[r_wp].value_word   <= r_item.value_word;
            r_q[r_wp].capture_flag <= r_item.capture_flag;
            r_q[r_wp].hash         <= n_acc;
        end
    end
endmodule
`default_nettype wire

[rtl/chte_back.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// chte_back
// Reduces the hash to a bucket by restoring division, walks the chain in
// the node memories and applies put, lookup or remove.
// ----------------------------------------------------------------------------
module chte_back #(
    parameter int unsigned BUCKETS = chte_pkg::BUCKETS_DEF,
    parameter int unsigned NODES   = chte_pkg::NODES_DEF
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_job_valid,
    input  chte_pkg::t_job      i_job,
    output logic                o_job_pop,
    input  wire [8:0]           i_bcount,
    output logic                o_strobe,
    output chte_pkg::t_out_item o_result
);
    import chte_pkg::*;

    localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int NW = $clog2(NODES + 1);
    localparam int IW = (NODES > 1) ? $clog2(NODES) : 1;
    localparam int DW = (BUCKETS > 256) ? 17 : 9;
    localparam logic [NW-1:0] NUL = NW'(NODES);

    t_bstate r_st, n_st;
    t_job    r_job;
    logic [DW-1:0] r_rem, r_div;
    logic [63:0]   r_q;
    logic [6:0]    r_bit;
    logic [BW-1:0] r_bkt;
    logic [NW-1:0] r_cur, r_prv, r_nxt, r_fh, r_fresh, r_found;
    logic [10:0]   r_live;
    logic [NW:0]   r_steps;
    logic [NW-1:0] r_heads [BUCKETS];
    logic [BUCKETS-1:0] r_hv;
    logic [63:0]   m_key [NODES];
    logic [63:0]   m_val [NODES];
    logic          m_flg [NODES];
    logic [NW-1:0] m_lnk [NODES];
    logic [63:0]   r_rk, r_rv;
    logic          r_rf;
    logic [NW-1:0] r_rl;
    logic [NW-1:0] r_hd;
    logic [BW-1:0] w_ha;
    logic [DW:0]   w_sh;
    logic [31:0]   w_bc;
    logic          w_hit;
    logic          r_lk_done;
    logic [1:0]    r_stat;
    logic [63:0]   r_fv;
    logic          r_ff;

    always_comb begin
        w_bc = 32'(i_bcount);
        if (w_bc > 32'(BUCKETS)) w_bc = 32'(BUCKETS);
        w_ha   = (r_st == B_MOD) ? ((r_div == '0) ? '0 : BW'(r_rem)) : r_bkt;
        w_sh   = {r_rem, r_q[63]};
        w_hit  = (r_rk == r_job.lookup_key);
    end

    assign o_job_pop = (r_st == B_IDLE) && i_job_valid;

    always_comb begin
        n_st = r_st;
        unique case (r_st)
            B_IDLE: if (i_job_valid) n_st = B_MOD;
            B_MOD: begin
                if (r_job.bad_key || r_job.operation == OP_NONE) n_st = B_DONE;
                else if (r_bit == 7'd0) n_st = B_HEAD;
            end
            B_HEAD: n_st = B_RD;
            B_RD: n_st = (r_cur == NUL || r_steps >= (NW+1)'(NODES)) ? B_WR : B_CMP;
            B_CMP: n_st = w_hit ? B_WR : B_RD;
            B_WR: n_st = B_FREE;
            B_FREE: n_st = B_DONE;
            B_DONE: n_st = B_IDLE;
            default: n_st = B_IDLE;
        endcase
    end

    always_comb begin
        o_strobe = (r_st == B_DONE);
        o_result.status      = r_stat;
        o_result.found_value = r_fv;
        o_result.found_flag  = r_ff;
        o_result.entry_count = r_live;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_st <= B_IDLE;
        else          r_st <= n_st;
    end

    // bucket head read, registered
    always_ff @(posedge i_clk) begin
        r_hd <= r_hv[w_ha] ? r_heads[w_ha] : NUL;
    end

    // control and datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hv    <= '0;
            r_fh    <= NUL;
            r_fresh <= '0;
            r_live  <= '0;
        end else begin
            case (r_st)
                B_IDLE: begin
                    if (i_job_valid) begin
                        r_job <= i_job;
                        r_div <= DW'(w_bc);
                        r_rem <= '0;
                        r_q   <= i_job.hash;
                        r_bit <= 7'd64;
                        r_fv  <= '0;
                        r_ff  <= 1'b0;
                        r_lk_done <= 1'b0;
                        if (i_job.bad_key) r_stat <= ST_BAD_KEY;
                        else if (i_job.operation == OP_NONE) r_stat <= ST_NOT_FOUND;
                        else r_stat <= ST_OK;
                    end
                end
                B_MOD: begin
                    if (r_bit != 7'd0) begin
                        r_q   <= {r_q[62:0], 1'b0};
                        r_bit <= r_bit - 7'd1;
                        if (w_sh >= {1'b0, r_div}) r_rem <= DW'(w_sh - {1'b0, r_div});
                        else                        r_rem <= DW'(w_sh);
                    end else begin
                        r_bkt <= w_ha;
                    end
                end
                B_HEAD: begin
                    r_cur   <= r_hd;
                    r_prv   <= NUL;
                    r_found <= NUL;
                    r_steps <= '0;
                end
                B_RD: ;
                B_CMP: begin
                    if (w_hit) begin
                        r_found <= r_cur;
                        r_nxt   <= r_rl;
                    end else begin
                        r_prv   <= r_cur;
                        r_cur   <= r_rl;
                        r_steps <= r_steps + 1'b1;
                    end
                end
                B_WR: begin
                    unique case (r_job.operation)
                        OP_PUT: begin
                            if (r_found == NUL) begin
                                if (r_fh != NUL) begin
                                    r_cur <= r_fh;
                                end else if (r_fresh != NUL) begin
                                    r_cur   <= r_fresh;
                                    r_fresh <= r_fresh + 1'b1;
                                end else begin
                                    r_stat <= ST_FULL;
                                end
                            end
                        end
                        OP_LOOKUP: begin
                            if (r_found == NUL) r_stat <= ST_NOT_FOUND;
                            else begin
                                r_fv <= r_rv;
                                r_ff <= r_rf;
                            end
                        end
                        OP_REMOVE: begin
                            if (r_found == NUL) r_stat <= ST_NOT_FOUND;
                            else begin
                                if (r_prv == NUL) begin
                                    r_heads[r_bkt] <= r_nxt;
                                    r_hv[r_bkt]    <= 1'b1;
                                end
                                if (r_live != '0) r_live <= r_live - 11'd1;
                            end
                        end
                        default: ;
                    endcase
                    r_lk_done <= (r_fh != NUL);
                end
                B_FREE: begin
                    if (r_job.operation == OP_PUT && r_found == NUL && r_stat == ST_OK) begin
                        if (r_lk_done) r_fh <= r_rl;
                        r_heads[r_bkt] <= r_cur;
                        r_hv[r_bkt]    <= 1'b1;
                        r_live <= r_live + 11'd1;
                    end
                    if (r_job.operation == OP_REMOVE && r_found != NUL) begin
                        r_fh <= r_found;
                    end
                end
                default: ;
            endcase
        end
    end

    // node memories: one write port, registered read
    logic          w_we;
    logic [IW-1:0] w_wa, w_ra;
    logic [63:0]   w_wk, w_wv;
    logic          w_wf, w_wl_only;
    logic [NW-1:0] w_wl;
    logic          w_fields;

    always_comb begin
        w_we = 1'b0; w_fields = 1'b0; w_wl_only = 1'b0;
        w_wa = IW'(r_cur); w_wk = r_job.lookup_key; w_wv = r_job.value_word;
        w_wf = r_job.capture_flag; w_wl = r_hd;
        w_ra = IW'(r_cur);
        if (r_st == B_WR && r_job.operation == OP_REMOVE && r_found != NUL
            && r_prv != NUL) begin
            w_we = 1'b1; w_wl_only = 1'b1; w_wa = IW'(r_prv); w_wl = r_nxt;
        end
        if (r_st == B_WR && r_job.operation == OP_PUT && r_found != NUL) begin
            w_we = 1'b1; w_fields = 1'b1; w_wa = IW'(r_found);
        end
        if (r_st == B_WR && r_job.operation == OP_PUT && r_found == NUL) begin
            w_ra = IW'(r_fh);
        end
        if (r_st == B_FREE && r_job.operation == OP_REMOVE && r_found != NUL) begin
            w_we = 1'b1; w_wl_only = 1'b1; w_wa = IW'(r_found); w_wl = r_fh;
        end
        if (r_st == B_FREE && r_job.operation == OP_PUT && r_found == NUL
            && r_stat == ST_OK) begin
            w_we = 1'b1; w_wa = IW'(r_cur); w_wl = r_hd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            if (!w_wl_only) begin
                m_val[w_wa] <= w_wv;
                m_flg[w_wa] <= w_wf;
                if (!w_fields) m_key[w_wa] <= w_wk;
            end
            if (!w_fields) m_lnk[w_wa] <= w_wl;
        end
        r_rk <= m_key[w_ra];
        r_rv <= m_val[w_ra];
        r_rf <= m_flg[w_ra];
        r_rl <= m_lnk[w_ra];
    end
endmodule
`default_nettype wire

[rtl/chained_hash_table_engine.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// chained_hash_table_engine
// Hash table with separate chaining over a fixed node pool.
//
//   port        dir  meaning
//   i_start     in   item request, taken when o_busy is low
//   o_strobe    out  result valid for one cycle
//   i_cfg_we    in   register write
//
// An item passes the multiplier, then a restoring division to reach its bucket
// head, then a read and a compare per chain node walked, then the write and free states.
// Key zero and operation code 3 skip the division and the chain walk.
// A two-entry job queue lets a new item be hashed while the back end works.
// Reset empties all buckets at once. Results cannot be stalled.
// ----------------------------------------------------------------------------
module chained_hash_table_engine #(
    parameter int unsigned BUCKETS = chte_pkg::BUCKETS_DEF,
    parameter int unsigned NODES   = chte_pkg::NODES_DEF
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_start,
    input  chte_pkg::t_in_item  i_item,
    output logic                o_busy,
    output logic                o_strobe,
    output chte_pkg::t_out_item o_result,
    input  wire                 i_cfg_we,
    input  wire                 i_cfg_idx,
    input  wire [63:0]          i_cfg_data
);
    import chte_pkg::*;

    logic [8:0]  r_bcount;
    logic [63:0] r_mult;
    logic        w_jv, w_pop;
    t_job        w_job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bcount <= 9'd256;
            r_mult   <= 64'd2654435761;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_BUCKETS: r_bcount <= i_cfg_data[8:0];
                CFG_MULT:    r_mult   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    chte_front u_front (
        .i_clk, .i_rst_n, .i_start, .i_item,
        .i_mult(r_mult), .o_busy,
        .o_job_valid(w_jv), .o_job(w_job), .i_job_pop(w_pop)
    );

    chte_back #(.BUCKETS(BUCKETS), .NODES(NODES)) u_back (
        .i_clk, .i_rst_n,
        .i_job_valid(w_jv), .i_job(w_job), .o_job_pop(w_pop),
        .i_bcount(r_bcount), .o_strobe, .o_result
    );
endmodule
`default_nettype wire

[tb/sv/chained_hash_table_engine_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// chained_hash_table_engine_test
// Self-checking bench for the chained hash table engine. A directed table
// covers key zero, the field extremes and every operation. Random puts,
// lookups and removes over small key sets then run under several bucket
// count and multiplier settings. Every result is checked against the bench's
// table model, or against a fixed result for a typed directed row.
// ----------------------------------------------------------------------------
module chained_hash_table_engine_test;
    import chte_pkg::*;

    localparam int NB = 256;
    localparam int NN = 1024;
    localparam int WATCHDOG = 20000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_start;
    t_in_item    i_item;
    logic        o_busy;
    logic        o_strobe;
    t_out_item   o_result;
    logic        i_cfg_we;
    logic        i_cfg_idx;
    logic [63:0] i_cfg_data;

    chained_hash_table_engine u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_start),
        .i_item     (i_item),
        .o_busy     (o_busy),
        .o_strobe   (o_strobe),
        .o_result   (o_result),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // table model
    logic [8:0]  mdl_buckets;
    logic [63:0] mdl_mult;
    int          mdl_heads[NB];
    logic [63:0] mdl_keys[NN];
    logic [63:0] mdl_vals[NN];
    logic        mdl_flags[NN];
    int          mdl_links[NN];
    int          mdl_free;
    int          mdl_fresh;
    int          mdl_live;

    t_out_item   expected_results[$];
    int          errors;
    int          idle_cycles;
    int          items_sent;
    int          results_seen;
    int          send_gap_pct;
    logic [63:0] key_pool[16];

    function automatic int bucket_of(logic [63:0] key);
        logic [63:0] h;
        int          n;
        h = key * mdl_mult;
        n = mdl_buckets;
        if (n == 0) return 0;
        if (n > NB) n = NB;
        return int'(h % 64'(n));
    endfunction

    function automatic t_out_item table_step(t_in_item it);
        t_out_item r;
        int        b;
        int        p;
        int        n;
        int        steps;
        int        nn;
        r = '0;
        if (it.lookup_key == 64'd0) begin
            r.status = ST_BAD_KEY;
        end else if (it.operation == OP_NONE) begin
            r.status = ST_NOT_FOUND;
        end else begin
            b = bucket_of(it.lookup_key);
            p = NN;
            n = mdl_heads[b];
            steps = 0;
            while (n < NN && steps < NN && mdl_keys[n] != it.lookup_key) begin
                p = n;
                n = mdl_links[n];
                steps++;
            end
            if (!(n < NN && steps < NN)) begin
                n = NN;
                p = NN;
            end
            case (it.operation)
                OP_PUT: begin
                    if (n < NN) begin
                        mdl_vals[n] = it.value_word;
                        mdl_flags[n] = it.capture_flag;
                    end else begin
                        nn = NN;
                        if (mdl_free < NN) begin
                            nn = mdl_free;
                            mdl_free = mdl_links[nn];
                        end else if (mdl_fresh < NN) begin
                            nn = mdl_fresh;
                            mdl_fresh++;
                        end
                        if (nn < NN) begin
                            mdl_keys[nn] = it.lookup_key;
                            mdl_vals[nn] = it.value_word;
                            mdl_flags[nn] = it.capture_flag;
                            mdl_links[nn] = mdl_heads[b];
                            mdl_heads[b] = nn;
                            mdl_live++;
                        end else begin
                            r.status = ST_FULL;
                        end
                    end
                end
                OP_LOOKUP: begin
                    if (n < NN) begin
                        r.found_value = mdl_vals[n];
                        r.found_flag = mdl_flags[n];
                    end else begin
                        r.status = ST_NOT_FOUND;
                    end
                end
                default: begin
                    if (n < NN) begin
                        if (p < NN) mdl_links[p] = mdl_links[n];
                        else mdl_heads[b] = mdl_links[n];
                        mdl_links[n] = mdl_free;
                        mdl_free = n;
                        if (mdl_live > 0) mdl_live--;
                    end else begin
                        r.status = ST_NOT_FOUND;
                    end
                end
            endcase
        end
        r.entry_count = 11'(mdl_live);
        return r;
    endfunction

    // result checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) begin
            results_seen <= results_seen + 1;
            if (expected_results.size() == 0) begin
                $error("result with nothing expected");
                errors++;
            end else begin
                t_out_item e;
                e = expected_results.pop_front();
                if (o_result.status !== e.status) begin
                    $error("status exp %0d got %0d", e.status, o_result.status);
                    errors++;
                end
                if (o_result.found_value !== e.found_value) begin
                    $error("found_value exp %h got %h", e.found_value,
                           o_result.found_value);
                    errors++;
                end
                if (o_result.found_flag !== e.found_flag) begin
                    $error("found_flag exp %0d got %0d", e.found_flag,
                           o_result.found_flag);
                    errors++;
                end
                if (o_result.entry_count !== e.entry_count) begin
                    $error("entry_count exp %0d got %0d", e.entry_count,
                           o_result.entry_count);
                    errors++;
                end
            end
        end
    end

    // watchdog on cycles without any accepted item or result
    always @(posedge i_clk) begin
        if (!i_rst_n || o_strobe || (i_start && !o_busy)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG) begin
                $display("[chained_hash_table_engine] ERROR");
                $finish;
            end
        end
    end

    task automatic send_item(t_in_item it, bit typed, t_out_item typed_res);
        t_out_item r;
        while ($urandom_range(99) < send_gap_pct) begin
            i_start <= 1'b0;
            @(posedge i_clk);
        end
        i_start <= 1'b1;
        i_item <= it;
        @(negedge i_clk);
        while (o_busy) @(negedge i_clk);
        @(posedge i_clk);
        r = table_step(it);
        if (typed) r = typed_res;
        expected_results.push_back(r);
        items_sent++;
    endtask

    task automatic drain();
        i_start <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [63:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_BUCKETS) mdl_buckets = data[8:0];
        else mdl_mult = data;
        @(posedge i_clk);
    endtask

    function automatic t_in_item make_item(t_op op, logic [63:0] k, logic [63:0] v, logic f);
        t_in_item it;
        it.operation = op;
        it.lookup_key = k;
        it.value_word = v;
        it.capture_flag = f;
        return it;
    endfunction

    function automatic t_out_item make_res(t_status s, logic [63:0] v, logic f, int c);
        t_out_item r;
        r.status = s;
        r.found_value = v;
        r.found_flag = f;
        r.entry_count = 11'(c);
        return r;
    endfunction

    typedef struct {
        t_in_item  it;
        bit        typed;
        t_out_item res;
    } t_row;

    task automatic random_phase(int count, int pct);
        t_in_item it;
        int       sel;
        send_gap_pct = pct;
        for (int i = 0; i < count; i++) begin
            sel = $urandom_range(99);
            it.value_word = {$urandom, $urandom};
            it.capture_flag = 1'($urandom_range(1));
            if (sel < 90) it.lookup_key = key_pool[4'($urandom_range(15))];
            else if (sel < 93) it.lookup_key = 64'd0;
            else it.lookup_key = {$urandom, $urandom};
            sel = $urandom_range(99);
            if (sel < 40) it.operation = OP_PUT;
            else if (sel < 70) it.operation = OP_LOOKUP;
            else if (sel < 96) it.operation = OP_REMOVE;
            else it.operation = OP_NONE;
            send_item(it, 1'b0, '0);
        end
    endtask

    task automatic new_keys();
        for (int i = 0; i < 16; i++) key_pool[i] = {$urandom, $urandom} | 64'd1;
        key_pool[0] = '1;
        key_pool[1] = 64'h8000_0000_0000_0000;
    endtask

    initial begin
        t_row rows[$];
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        i_start = 1'b0;
        i_item = '0;
        i_cfg_we = 1'b0;
        i_cfg_idx = CFG_BUCKETS;
        i_cfg_data = '0;
        errors = 0;
        items_sent = 0;
        results_seen = 0;
        idle_cycles = 0;
        send_gap_pct = 24;
        mdl_buckets = 9'd256;
        mdl_mult = 64'd2654435761;
        for (int i = 0; i < NB; i++) mdl_heads[i] = NN;
        for (int i = 0; i < NN; i++) begin
            mdl_keys[i] = '0;
            mdl_vals[i] = '0;
            mdl_flags[i] = 1'b0;
            mdl_links[i] = NN;
        end
        mdl_free = NN;
        mdl_fresh = 0;
        mdl_live = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        rows.push_back('{make_item(OP_LOOKUP, 64'd5, '1, 1'b1), 1,
                         make_res(ST_NOT_FOUND, 0, 0, 0)});
        rows.push_back('{make_item(OP_PUT, 64'd0, '1, 1'b1), 1,
                         make_res(ST_BAD_KEY, 0, 0, 0)});
        rows.push_back('{make_item(OP_PUT, '1, '1, 1'b1), 1,
                         make_res(ST_OK, 0, 0, 1)});
        rows.push_back('{make_item(OP_LOOKUP, '1, '0, 1'b0), 1,
                         make_res(ST_OK, '1, 1, 1)});
        rows.push_back('{make_item(OP_PUT, 64'd1, '0, 1'b0), 1,
                         make_res(ST_OK, 0, 0, 2)});
        rows.push_back('{make_item(OP_LOOKUP, 64'd1, '1, 1'b1), 1,
                         make_res(ST_OK, 0, 0, 2)});
        rows.push_back('{make_item(OP_PUT, '1, 64'h0123_4567_89ab_cdef, 1'b0), 0, '0});
        rows.push_back('{make_item(OP_LOOKUP, '1, '0, 1'b1), 0, '0});
        rows.push_back('{make_item(OP_NONE, '1, '0, 1'b0), 1,
                         make_res(ST_NOT_FOUND, 0, 0, 2)});
        rows.push_back('{make_item(OP_REMOVE, 64'd0, '0, 1'b0), 1,
                         make_res(ST_BAD_KEY, 0, 0, 2)});
        rows.push_back('{make_item(OP_REMOVE, 64'd77, '0, 1'b0), 1,
                         make_res(ST_NOT_FOUND, 0, 0, 2)});
        rows.push_back('{make_item(OP_REMOVE, '1, '0, 1'b0), 1,
                         make_res(ST_OK, 0, 0, 1)});
        rows.push_back('{make_item(OP_LOOKUP, '1, '0, 1'b0), 1,
                         make_res(ST_NOT_FOUND, 0, 0, 1)});
        rows.push_back('{make_item(OP_PUT, 64'h8000_0000_0000_0000, '1, 1'b1), 0, '0});
        rows.push_back('{make_item(OP_REMOVE, 64'd1, '0, 1'b0), 0, '0});
        rows.push_back('{make_item(OP_LOOKUP, 64'h8000_0000_0000_0000, 0, 0), 0, '0});
        foreach (rows[i]) send_item(rows[i].it, rows[i].typed, rows[i].res);
        drain();

        // single bucket chains
        write_reg(CFG_BUCKETS, 64'd1);
        write_reg(CFG_MULT, 64'd0);
        send_gap_pct = 0;
        new_keys();
        for (int i = 0; i < 6; i++)
            send_item(make_item(OP_PUT, key_pool[i], {$urandom, $urandom}, 1'b1), 0, '0);
        send_item(make_item(OP_REMOVE, key_pool[3], '0, 1'b0), 0, '0);
        send_item(make_item(OP_REMOVE, key_pool[0], '0, 1'b0), 0, '0);
        send_item(make_item(OP_LOOKUP, key_pool[5], '0, 1'b0), 0, '0);
        drain();

        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: write_reg(CFG_BUCKETS, 64'd0);
                1: write_reg(CFG_BUCKETS, 64'd7);
                2: write_reg(CFG_BUCKETS, 64'h1ff);
                3: write_reg(CFG_BUCKETS, 64'($urandom_range(1, 256)));
                4: write_reg(CFG_BUCKETS, 64'd256);
                default: write_reg(CFG_BUCKETS, 64'd2);
            endcase
            if (ph == 2) write_reg(CFG_MULT, '1);
            else write_reg(CFG_MULT, {$urandom, $urandom});
            new_keys();
            random_phase(90, ph < 2 ? 24 : (ph < 4 ? 73 : 0));
            drain();
        end

        $display("sent %0d items, checked %0d results over eight register settings",
                 items_sent, results_seen);
        if (errors == 0) begin
            $display("[chained_hash_table_engine] OK");
        end else begin
            $display("[chained_hash_table_engine] ERROR");
        end
        $finish;
    end
endmodule

[files.f]
rtl/chte_pkg.sv
rtl/chte_front.sv
rtl/chte_back.sv
rtl/chained_hash_table_engine.sv
tb/sv/chained_hash_table_engine_test.sv
